/* rtl/pwmtc_pkg.sv */
// ----------------------------------------------------------------------------
// pwmtc_pkg
// Constants shared by the PWM timing calculator: field widths, mode codes,
// saturation limits, frequency bands and serial step counts.
// ----------------------------------------------------------------------------
package pwmtc_pkg;

  localparam int DEF_NUM_CHANNELS = 2;

  localparam int MODE_W = 2;
  localparam int FREQ_W = 17;
  localparam int DUTY_W = 7;
  localparam int PSC_W  = 13;
  localparam int REL_W  = 16;
  localparam int CLK_W  = 24;
  localparam int PROD_W = 23;
  localparam int PREM_W = 7;

  localparam logic [MODE_W-1:0] MODE_SET    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENABLE = 2'd1;

  localparam logic [FREQ_W-1:0] FREQ_MAX = 17'd100000;
  localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

  localparam logic [FREQ_W-1:0] BAND0_MAX = 17'd100;
  localparam logic [FREQ_W-1:0] BAND1_MAX = 17'd1000;
  localparam logic [FREQ_W-1:0] BAND2_MAX = 17'd10000;

  localparam logic [PSC_W-1:0] PSC_BAND0 = 13'd7199;
  localparam logic [PSC_W-1:0] PSC_BAND1 = 13'd719;
  localparam logic [PSC_W-1:0] PSC_BAND2 = 13'd71;
  localparam logic [PSC_W-1:0] PSC_BAND3 = 13'd7;

  localparam logic [CLK_W-1:0] CLK_BAND0 = 24'd10000;
  localparam logic [CLK_W-1:0] CLK_BAND1 = 24'd100000;
  localparam logic [CLK_W-1:0] CLK_BAND2 = 24'd1000000;
  localparam logic [CLK_W-1:0] CLK_BAND3 = 24'd9000000;

  localparam logic [CLK_W-1:0] COUNT_MIN = 24'd100;
  localparam logic [CLK_W-1:0] COUNT_MAX = 24'd65535;

  localparam logic [PREM_W:0] PCT_DIV = 8'd100;

  localparam logic [REL_W-1:0] RESET_RELOAD = 16'd999;
  localparam logic [PSC_W-1:0] RESET_PSC    = 13'd71;

  localparam int DIV_STEPS = CLK_W;
  localparam int MUL_STEPS = DUTY_W;
  localparam int PCT_STEPS = PROD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

endpackage

/* rtl/pwm_timing_calculator.sv */
// ----------------------------------------------------------------------------
// pwm_timing_calculator
// Turns a PWM frequency and duty request into prescaler, reload and compare
// values for a channel timer, using bit-serial division and multiplication.
// ----------------------------------------------------------------------------
// One transaction at a time. A set-timing transaction runs, from acceptance
// to result, through the restoring divider (counter clock by frequency, one
// quotient bit per cycle), a clamp step, shift-add steps for count times duty
// and division by 100, then the output load. An enable transaction skips the
// divider and clamp; disable, the unused mode code and an out-of-range channel
// go straight to the output load. A new transaction is accepted once the
// result is loaded into the output register, even if that result has not yet
// been taken.
module pwm_timing_calculator
  import pwmtc_pkg::*;
#(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [MODE_W-1:0] mode,
  input  logic              channel,
  input  logic [FREQ_W-1:0] frequency,
  input  logic [DUTY_W-1:0] duty,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic              out_channel,
  output logic [PSC_W-1:0]  prescaler,
  output logic [REL_W-1:0]  reload,
  output logic [REL_W-1:0]  compare,
  output logic              timing_written
);

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CLMP,
    ST_MUL,
    ST_PCT,
    ST_FIN
  } state_t;

  state_t st;
  logic [STEP_W-1:0] step;
  logic              ch_r;
  logic              wr_r;
  logic [DUTY_W-1:0] duty_r;
  logic [FREQ_W-1:0] freq_r;
  logic [PSC_W-1:0]  psc_r;
  logic [REL_W-1:0]  rel_r;
  logic [REL_W-1:0]  cnt_r;
  logic [FREQ_W-1:0] rem;
  logic [CLK_W-1:0]  quo;
  logic [PROD_W-1:0] acc;
  logic [PREM_W-1:0] prem;

  logic [DUTY_W-1:0] duty_cache       [NUM_CHANNELS];
  logic [REL_W-1:0]  stored_reload    [NUM_CHANNELS];
  logic [PSC_W-1:0]  stored_prescaler [NUM_CHANNELS];

  logic [CH_IDX_W-1:0] in_idx;
  logic [CH_IDX_W-1:0] r_idx;
  logic                ch_ok;
  logic [FREQ_W-1:0]   f_sat;
  logic [DUTY_W-1:0]   d_sat;
  logic [PSC_W-1:0]    band_psc;
  logic [CLK_W-1:0]    band_clk;
  logic [FREQ_W:0]     div_sh;
  logic                div_ge;
  logic [CLK_W-1:0]    count_cl;
  logic [PREM_W:0]     pct_sh;
  logic                pct_ge;
  logic                out_free;
  logic                out_load;

  assign in_idx   = CH_IDX_W'(channel);
  assign r_idx    = CH_IDX_W'(ch_r);
  assign ch_ok    = (32'(channel) < 32'(NUM_CHANNELS));
  assign req_ready = (st == ST_IDLE);
  assign out_free = !rsp_valid || rsp_ready;
  assign out_load = (st == ST_FIN) && out_free;

  always_comb begin
    f_sat = frequency;
    if (frequency == '0) begin
      f_sat = FREQ_W'(1);
    end else if (frequency > FREQ_MAX) begin
      f_sat = FREQ_MAX;
    end
    d_sat = (duty > DUTY_MAX) ? DUTY_MAX : duty;
    if (f_sat <= BAND0_MAX) begin
      band_psc = PSC_BAND0;
      band_clk = CLK_BAND0;
    end else if (f_sat <= BAND1_MAX) begin
      band_psc = PSC_BAND1;
      band_clk = CLK_BAND1;
    end else if (f_sat <= BAND2_MAX) begin
      band_psc = PSC_BAND2;
      band_clk = CLK_BAND2;
    end else begin
      band_psc = PSC_BAND3;
      band_clk = CLK_BAND3;
    end
  end

  // restoring division steps
  assign div_sh = {rem, quo[CLK_W-1]};
  assign div_ge = (div_sh >= {1'b0, freq_r});
  assign pct_sh = {prem, acc[PROD_W-1]};
  assign pct_ge = (pct_sh >= PCT_DIV);

  always_comb begin
    if (quo < COUNT_MIN) begin
      count_cl = COUNT_MIN;
    end else if (quo > COUNT_MAX) begin
      count_cl = COUNT_MAX;
    end else begin
      count_cl = quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      step      <= '0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        duty_cache[i]       <= '0;
        stored_reload[i]    <= RESET_RELOAD;
        stored_prescaler[i] <= RESET_PSC;
      end
    end else begin
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (st)
        ST_IDLE: begin
          if (req_valid) begin
            ch_r <= channel;
            acc  <= '0;
            if (!ch_ok) begin
              psc_r <= '0;
              rel_r <= '0;
              wr_r  <= 1'b0;
              st    <= ST_FIN;
            end else if (mode == MODE_SET) begin
              duty_r <= d_sat;
              freq_r <= f_sat;
              psc_r  <= band_psc;
              quo    <= band_clk;
              rem    <= '0;
              wr_r   <= 1'b1;
              step   <= STEP_W'(DIV_STEPS - 1);
              st     <= ST_DIV;
            end else begin
              psc_r  <= stored_prescaler[in_idx];
              rel_r  <= stored_reload[in_idx];
              cnt_r  <= REL_W'(stored_reload[in_idx] + REL_W'(1));
              duty_r <= duty_cache[in_idx];
              wr_r   <= 1'b0;
              if (mode == MODE_ENABLE) begin
                step <= STEP_W'(MUL_STEPS - 1);
                st   <= ST_MUL;
              end else begin
                st <= ST_FIN;
              end
            end
          end
        end
        ST_DIV: begin
          rem  <= div_ge ? FREQ_W'(div_sh - {1'b0, freq_r}) : FREQ_W'(div_sh);
          quo  <= {quo[CLK_W-2:0], div_ge};
          step <= step - STEP_W'(1);
          if (step == '0) begin
            st <= ST_CLMP;
          end
        end
        ST_CLMP: begin
          cnt_r                   <= REL_W'(count_cl);
          rel_r                   <= REL_W'(count_cl - CLK_W'(1));
          duty_cache[r_idx]       <= duty_r;
          stored_reload[r_idx]    <= REL_W'(count_cl - CLK_W'(1));
          stored_prescaler[r_idx] <= psc_r;
          step                    <= STEP_W'(MUL_STEPS - 1);
          st                      <= ST_MUL;
        end
        ST_MUL: begin
          acc    <= {acc[PROD_W-2:0], 1'b0} + (duty_r[DUTY_W-1] ? PROD_W'(cnt_r) : '0);
          duty_r <= {duty_r[DUTY_W-2:0], 1'b0};
          if (step == '0) begin
            prem <= '0;
            step <= STEP_W'(PCT_STEPS - 1);
            st   <= ST_PCT;
          end else begin
            step <= step - STEP_W'(1);
          end
        end
        ST_PCT: begin
          prem <= pct_ge ? PREM_W'(pct_sh - PCT_DIV) : PREM_W'(pct_sh);
          acc  <= {acc[PROD_W-2:0], pct_ge};
          step <= step - STEP_W'(1);
          if (step == '0) begin
            st <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_channel    <= ch_r;
            prescaler      <= psc_r;
            reload         <= rel_r;
            compare        <= acc[REL_W-1:0];
            timing_written <= wr_r;
            st             <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  a_cmp_le_period: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ({1'b0, compare} <= ({1'b0, reload} + 17'd1)))
    else $error("compare exceeds period count");

  a_reload_min: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && timing_written) |-> (reload >= REL_W'(COUNT_MIN - CLK_W'(1))))
    else $error("new reload below minimum period");

  a_psc_band: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && timing_written) |->
      (prescaler == PSC_BAND0 || prescaler == PSC_BAND1 ||
       prescaler == PSC_BAND2 || prescaler == PSC_BAND3))
    else $error("new prescaler is not a band value");

  a_div_step: assert property (@(posedge clk) disable iff (rst)
    (st == ST_DIV) |-> (32'(step) < DIV_STEPS))
    else $error("divider step count out of range");

  a_fin_load: assert property (@(posedge clk) disable iff (rst)
    ((st == ST_FIN) && out_free) |=> (rsp_valid && req_ready))
    else $error("finished result not loaded");

endmodule
